>>> rtl/rqi_pkg.sv
// ----------------------------------------------------------------------------
// rqi_pkg: shared constants, types and helpers
// Defaults, register indexes, the configuration bundle and saturation.
// ----------------------------------------------------------------------------
package rqi_pkg;

  localparam int COORD_WIDTH_DEF = 21;
  localparam int FRAC_BITS_DEF   = 11;
  localparam int CFG_W           = 63;
  localparam int IDX_W           = 3;
  localparam int QUEUE_DEPTH     = 4;
  // wide enough for any sum of products at the largest coordinate width
  localparam int SW              = 72;

  // register indexes
  localparam logic [IDX_W-1:0] REG_CORNER = 3'd0;
  localparam logic [IDX_W-1:0] REG_EDGE_U = 3'd1;
  localparam logic [IDX_W-1:0] REG_EDGE_V = 3'd2;
  localparam logic [IDX_W-1:0] REG_NORMAL = 3'd3;
  localparam logic [IDX_W-1:0] REG_SCALED = 3'd4;
  localparam logic [IDX_W-1:0] REG_OFFSET = 3'd5;
  localparam logic [IDX_W-1:0] REG_LIMIT  = 3'd6;

  // configuration bundle; offset and limit sit in the low bits
  typedef struct packed {
    logic [CFG_W-1:0] corner;
    logic [CFG_W-1:0] edge_u;
    logic [CFG_W-1:0] edge_v;
    logic [CFG_W-1:0] normal;
    logic [CFG_W-1:0] scaled;
    logic [31:0]      offset;
    logic [31:0]      limit;
  } rqi_cfg_t;

  // clamp to the signed range of w bits
  function automatic logic signed [SW-1:0] sat_w(input logic signed [SW-1:0] v,
                                                 input int unsigned w);
    logic signed [SW-1:0] mx;
    logic signed [SW-1:0] mn;
    mx = (SW'(1) <<< (w - 1)) - SW'(1);
    mn = -mx - SW'(1);
    if (v > mx) return mx;
    if (v < mn) return mn;
    return v;
  endfunction

endpackage

>>> rtl/rqi_front.sv
// ----------------------------------------------------------------------------
// rqi_front: plane test front end
// Forms n.dir and offset - n.origin, and flags rays parallel to the plane.
// ----------------------------------------------------------------------------
module rqi_front import rqi_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int W   = COORD_WIDTH,
  localparam int QDW = 10 * COORD_WIDTH + 1
) (
  input  logic           clk,
  input  logic           rst,
  input  rqi_cfg_t       cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [8*W-1:0] in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [QDW-1:0] out_data
);

  logic                     fe;
  logic                     s1_v;
  logic [8*W-1:0]           s1_ray;
  logic signed [2*W-1:0]    s1_pd [3];
  logic signed [2*W-1:0]    s1_po [3];
  logic                     s2_v;
  logic [QDW-1:0]           s2_data;
  logic signed [SW-1:0]     sum_d, sum_o, num_w;
  logic [W-1:0]             den, num, mag;
  logic                     par;

  function automatic logic [W-1:0] comp(input logic [CFG_W-1:0] r, input int i);
    logic [3*W+CFG_W-1:0] e;
    e = {{(3*W){1'b0}}, r};
    return e[i*W +: W];
  endfunction

  function automatic logic signed [2*W-1:0] mulsh(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
    logic signed [2*W-1:0] pr;
    pr = a * b;
    return pr >>> FRAC_BITS;
  endfunction

  assign fe        = !s2_v || out_ready;
  assign in_ready  = fe;
  assign out_valid = s2_v;
  assign out_data  = s2_data;

  // sums, saturation and the parallel test
  always_comb begin
    sum_d = sat_w(SW'(s1_pd[0]) + SW'(s1_pd[1]) + SW'(s1_pd[2]), W);
    sum_o = sat_w(SW'(s1_po[0]) + SW'(s1_po[1]) + SW'(s1_po[2]), W);
    num_w = sat_w(SW'($signed(cfg.offset[W-1:0])) - sum_o, W);
    den   = sum_d[W-1:0];
    num   = num_w[W-1:0];
    mag   = den[W-1] ? (~den + 1'b1) : den;
    par   = (den == '0) || (mag < W'(cfg.limit[W-2:0]));
  end

  // two stages, both held while the queue is full
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else if (fe) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
    end
    if (fe) begin
      s1_ray <= in_data;
      for (int i = 0; i < 3; i++) begin
        s1_pd[i] <= mulsh($signed(comp(cfg.normal, i)), $signed(in_data[(3+i)*W +: W]));
        s1_po[i] <= mulsh($signed(comp(cfg.normal, i)), $signed(in_data[i*W +: W]));
      end
      s2_data <= {par, den, num, s1_ray};
    end
  end

endmodule

>>> rtl/rqi_fifo.sv
// ----------------------------------------------------------------------------
// rqi_fifo: small request queue
// Decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rqi_fifo import rqi_pkg::*; #(
  parameter int DW    = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [DW-1:0] in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [DW-1:0] out_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] wr, rd;
  logic [AW:0]   count;
  logic          push, pop;

  assign in_ready  = count != (AW+1)'(DEPTH);
  assign out_valid = count != '0;
  assign out_data  = mem[rd];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr    <= '0;
      rd    <= '0;
      count <= '0;
    end else begin
      if (push) wr <= (wr == AW'(DEPTH-1)) ? '0 : wr + 1'b1;
      if (pop)  rd <= (rd == AW'(DEPTH-1)) ? '0 : rd + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
    if (push) mem[wr] <= in_data;
  end

endmodule

>>> rtl/rqi_back.sv
// ----------------------------------------------------------------------------
// rqi_back: intersection back end
// Pipelined divide for t, then hit point, planar coordinates and result.
// ----------------------------------------------------------------------------
module rqi_back import rqi_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int W   = COORD_WIDTH,
  localparam int F   = FRAC_BITS,
  localparam int QDW = 10 * COORD_WIDTH + 1,
  localparam int ODW = 7 * COORD_WIDTH + 2 * FRAC_BITS + 4
) (
  input  logic           clk,
  input  logic           rst,
  input  rqi_cfg_t       cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [QDW-1:0] in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [ODW-1:0] out_data
);

  localparam int QW  = W + F;
  localparam int KT  = QW + 1;
  localparam int KP1 = QW + 2;
  localparam int KP2 = QW + 3;
  localparam int KR  = QW + 4;
  localparam int KC1 = QW + 5;
  localparam int KC2 = QW + 6;
  localparam int KD1 = QW + 7;
  localparam int KD2 = QW + 8;
  localparam int NS  = QW + 9;
  localparam logic signed [SW-1:0] ONE_Q = SW'(1) <<< F;

  typedef struct packed {
    logic [2:0][W-1:0]     o, d, p, rel, cra, crb, fn;
    logic [W-1:0]          tmin, tmax, t, dvs, rem;
    logic [QW-1:0]         dvd, quo;
    logic [11:0][2*W-1:0]  pr;
    logic                  par, neg, dneg, miss, hit, ff;
    logic [F:0]            u, v;
  } bk_t;

  bk_t                  st [NS];
  bk_t                  nx [NS];
  logic [NS-1:0]        sv;
  logic                 be;
  logic [W-1:0]         an, ad;
  logic [W:0]           rem2;
  logic signed [SW-1:0] tq, al, bt;

  function automatic logic [W-1:0] comp(input logic [CFG_W-1:0] r, input int i);
    logic [3*W+CFG_W-1:0] e;
    e = {{(3*W){1'b0}}, r};
    return e[i*W +: W];
  endfunction

  function automatic logic [2*W-1:0] mulsh(input logic [W-1:0] a, input logic [W-1:0] b);
    logic signed [2*W-1:0] pr;
    pr = $signed(a) * $signed(b);
    return pr >>> F;
  endfunction

  function automatic logic signed [SW-1:0] sx(input logic [W-1:0] x);
    return SW'($signed(x));
  endfunction

  function automatic logic signed [SW-1:0] sp(input logic [2*W-1:0] x);
    return SW'($signed(x));
  endfunction

  function automatic logic [W-1:0] sw(input logic signed [SW-1:0] x);
    logic signed [SW-1:0] r;
    r = sat_w(x, W);
    return r[W-1:0];
  endfunction

  assign be        = !sv[NS-1] || out_ready;
  assign in_ready  = be;
  assign out_valid = sv[NS-1];
  assign out_data  = {st[NS-1].v, st[NS-1].u, st[NS-1].ff, st[NS-1].fn,
                      st[NS-1].p, st[NS-1].t, st[NS-1].hit};

  // stage logic: load, one quotient bit per stage, then the geometry
  always_comb begin
    an = in_data[9*W-1] ? (~in_data[9*W-1:8*W] + 1'b1) : in_data[9*W-1:8*W];
    ad = in_data[10*W-1] ? (~in_data[10*W-1:9*W] + 1'b1) : in_data[10*W-1:9*W];
    rem2 = '0;
    tq = '0;
    al = '0;
    bt = '0;
    nx[0]      = '0;
    nx[0].o    = in_data[3*W-1:0];
    nx[0].d    = in_data[6*W-1:3*W];
    nx[0].tmin = in_data[7*W-1:6*W];
    nx[0].tmax = in_data[8*W-1:7*W];
    nx[0].par  = in_data[10*W];
    nx[0].neg  = in_data[9*W-1] ^ in_data[10*W-1];
    nx[0].dneg = in_data[10*W-1];
    nx[0].dvs  = ad;
    nx[0].dvd  = {an, F'(0)};
    for (int k = 1; k < NS; k++) begin
      nx[k] = st[k-1];
      if (k <= QW) begin
        rem2 = {st[k-1].rem, st[k-1].dvd[QW-1]};
        nx[k].dvd = st[k-1].dvd << 1;
        if (rem2 >= {1'b0, st[k-1].dvs}) begin
          nx[k].rem = W'(rem2 - {1'b0, st[k-1].dvs});
          nx[k].quo = {st[k-1].quo[QW-2:0], 1'b1};
        end else begin
          nx[k].rem = rem2[W-1:0];
          nx[k].quo = {st[k-1].quo[QW-2:0], 1'b0};
        end
      end else if (k == KT) begin
        tq = st[k-1].neg ? -SW'(st[k-1].quo) : SW'(st[k-1].quo);
        nx[k].t = sw(tq);
        nx[k].miss = st[k-1].par || (sx(nx[k].t) < sx(st[k-1].tmin)) ||
                     (sx(nx[k].t) > sx(st[k-1].tmax));
      end else if (k == KP1) begin
        for (int i = 0; i < 3; i++) nx[k].pr[i] = mulsh(st[k-1].t, st[k-1].d[i]);
      end else if (k == KP2) begin
        for (int i = 0; i < 3; i++) nx[k].p[i] = sw(sx(st[k-1].o[i]) + sp(st[k-1].pr[i]));
      end else if (k == KR) begin
        for (int i = 0; i < 3; i++)
          nx[k].rel[i] = sw(sx(st[k-1].p[i]) - sx(comp(cfg.corner, i)));
      end else if (k == KC1) begin
        // rel x ev
        nx[k].pr[0]  = mulsh(st[k-1].rel[1], comp(cfg.edge_v, 2));
        nx[k].pr[1]  = mulsh(st[k-1].rel[2], comp(cfg.edge_v, 1));
        nx[k].pr[2]  = mulsh(st[k-1].rel[2], comp(cfg.edge_v, 0));
        nx[k].pr[3]  = mulsh(st[k-1].rel[0], comp(cfg.edge_v, 2));
        nx[k].pr[4]  = mulsh(st[k-1].rel[0], comp(cfg.edge_v, 1));
        nx[k].pr[5]  = mulsh(st[k-1].rel[1], comp(cfg.edge_v, 0));
        // eu x rel
        nx[k].pr[6]  = mulsh(comp(cfg.edge_u, 1), st[k-1].rel[2]);
        nx[k].pr[7]  = mulsh(comp(cfg.edge_u, 2), st[k-1].rel[1]);
        nx[k].pr[8]  = mulsh(comp(cfg.edge_u, 2), st[k-1].rel[0]);
        nx[k].pr[9]  = mulsh(comp(cfg.edge_u, 0), st[k-1].rel[2]);
        nx[k].pr[10] = mulsh(comp(cfg.edge_u, 0), st[k-1].rel[1]);
        nx[k].pr[11] = mulsh(comp(cfg.edge_u, 1), st[k-1].rel[0]);
      end else if (k == KC2) begin
        for (int i = 0; i < 3; i++) begin
          nx[k].cra[i] = sw(sp(st[k-1].pr[2*i]) - sp(st[k-1].pr[2*i+1]));
          nx[k].crb[i] = sw(sp(st[k-1].pr[6+2*i]) - sp(st[k-1].pr[7+2*i]));
        end
      end else if (k == KD1) begin
        for (int i = 0; i < 3; i++) begin
          nx[k].pr[i]   = mulsh(comp(cfg.scaled, i), st[k-1].cra[i]);
          nx[k].pr[3+i] = mulsh(comp(cfg.scaled, i), st[k-1].crb[i]);
        end
      end else if (k == KD2) begin
        al = sat_w(sp(st[k-1].pr[0]) + sp(st[k-1].pr[1]) + sp(st[k-1].pr[2]), W);
        bt = sat_w(sp(st[k-1].pr[3]) + sp(st[k-1].pr[4]) + sp(st[k-1].pr[5]), W);
        nx[k].miss = st[k-1].miss || (al < 0) || (al > ONE_Q) || (bt < 0) || (bt > ONE_Q);
        nx[k].hit  = !nx[k].miss;
        nx[k].ff   = !nx[k].miss && st[k-1].dneg;
        nx[k].u    = nx[k].miss ? '0 : al[F:0];
        nx[k].v    = nx[k].miss ? '0 : bt[F:0];
        if (nx[k].miss) begin
          nx[k].t = '0;
          nx[k].p = '0;
        end
        for (int i = 0; i < 3; i++) begin
          if (nx[k].miss)
            nx[k].fn[i] = '0;
          else if (st[k-1].dneg)
            nx[k].fn[i] = comp(cfg.normal, i);
          else
            nx[k].fn[i] = sw(-sx(comp(cfg.normal, i)));
        end
      end
    end
  end

  // whole back end advances together; the last stage is the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else if (be) begin
      sv <= {sv[NS-2:0], in_valid};
    end
    if (be) begin
      for (int k = 0; k < NS; k++) st[k] <= nx[k];
    end
  end

endmodule

>>> rtl/ray_quad_intersect.sv
// ----------------------------------------------------------------------------
// ray_quad_intersect: ray against parallelogram test
// Top level with configuration registers, front end, queue and back end.
// ----------------------------------------------------------------------------
// Usage:
//  - Write the quad (corner, edges, unit normal, scaled normal, plane offset,
//    parallel limit) through cfg_we/cfg_index/cfg_data while no ray is in
//    flight. Reset sets all registers to zero and the parallel limit to one.
//  - Rays enter on s_axis_*, one request per cycle when s_axis_tready is up.
//  - Each ray gives exactly one result on m_axis_*, in order; a miss returns
//    hit low and all other fields zero.
//  - The hit distance t is formed by a one-bit-per-stage divider.
//  - Throughput: one ray per cycle sustained while m_axis_tready stays up.
//  - A stall on m_axis_tready freezes the back end; the front end keeps
//    filling a four-entry queue and then drops s_axis_tready.
//  - Reset empties the pipelines and the queue.
// ----------------------------------------------------------------------------
module ray_quad_intersect import rqi_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int IDW = ((8 * COORD_WIDTH + 7) / 8) * 8,
  localparam int ODW = 7 * COORD_WIDTH + 2 * FRAC_BITS + 4,
  localparam int OTW = ((ODW + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_min, t_max
  input  logic [IDW-1:0]   s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // hit, hit_distance, point_x/y/z, face_normal_x/y/z, front_face, coord_u, coord_v
  output logic [OTW-1:0]   m_axis_tdata,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int W   = COORD_WIDTH;
  localparam int QDW = 10 * W + 1;

  logic [CFG_W-1:0] corner, edge_u, edge_v, normal, scaled;
  logic [W-1:0]     offset;
  logic [W-2:0]     limit;
  rqi_cfg_t         cfg;
  logic             f_valid, f_ready, b_valid, b_ready;
  logic [QDW-1:0]   f_data, b_data;
  logic [ODW-1:0]   o_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      corner <= '0;
      edge_u <= '0;
      edge_v <= '0;
      normal <= '0;
      scaled <= '0;
      offset <= '0;
      limit  <= (W-1)'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CORNER: corner <= cfg_data;
        REG_EDGE_U: edge_u <= cfg_data;
        REG_EDGE_V: edge_v <= cfg_data;
        REG_NORMAL: normal <= cfg_data;
        REG_SCALED: scaled <= cfg_data;
        REG_OFFSET: offset <= cfg_data[W-1:0];
        REG_LIMIT:  limit  <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  assign cfg = '{corner: corner, edge_u: edge_u, edge_v: edge_v, normal: normal,
                 scaled: scaled, offset: 32'(offset), limit: 32'(limit)};

  rqi_front #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .cfg,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(s_axis_tdata[8*W-1:0]),
    .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
  );

  rqi_fifo #(.DW(QDW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
    .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
  );

  rqi_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .cfg,
    .in_valid(b_valid), .in_ready(b_ready), .in_data(b_data),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(o_data)
  );

  assign m_axis_tdata = OTW'(o_data);

`ifndef NO_ASSERTIONS
  // a miss carries nothing but zeros
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> o_data[ODW-1:1] == '0)
    else $error("miss result with nonzero fields");

  // coordinates of a hit lie in [0,1]
  a_coord_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |->
      o_data[7*W+FRAC_BITS+2 -: FRAC_BITS+1] <= (FRAC_BITS+1)'(1 << FRAC_BITS) &&
      o_data[ODW-1 -: FRAC_BITS+1] <= (FRAC_BITS+1)'(1 << FRAC_BITS))
    else $error("planar coordinate out of range");

  // front face is only reported on a hit
  a_front_hit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && o_data[7*W+1] |-> o_data[0])
    else $error("front face without hit");
`endif

endmodule
